>>> rtl/core/lkv_pkg.sv
// shared types and constants for the lru key-value cache
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned XW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             evict;
    logic [IDX_W-1:0] slot;
  } lookup_t;

endpackage
`default_nettype wire

>>> rtl/core/lkv_value_ram.sv
// value storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module lkv_value_ram (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [lkv_pkg::IDX_W-1:0]       waddr_i,
  input  wire logic [lkv_pkg::DATA_W-1:0]      wdata_i,
  input  wire logic [lkv_pkg::IDX_W-1:0]       raddr_i,
  output      logic [lkv_pkg::DATA_W-1:0]      rdata_o
);

  logic [lkv_pkg::DATA_W-1:0] mem [lkv_pkg::ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/lkv_tag_store.sv
// key tags, valid bits and recency ranks with parallel match and lru update
`timescale 1ns / 1ps
`default_nettype none
module lkv_tag_store (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            lookup_en_i,
  input  wire logic                            action_i,
  input  wire logic signed [lkv_pkg::DATA_W-1:0] key_i,
  input  wire logic [lkv_pkg::CFG_W-1:0]       cap_i,
  output      lkv_pkg::lookup_t                res_o
);

  logic                        valid_q [lkv_pkg::ENTRIES];
  logic                        valid_ev [lkv_pkg::ENTRIES];
  logic [lkv_pkg::IDX_W-1:0]   rank_q [lkv_pkg::ENTRIES];
  logic [lkv_pkg::IDX_W-1:0]   rank_d [lkv_pkg::ENTRIES];
  logic [lkv_pkg::DATA_W-1:0]  key_q [lkv_pkg::ENTRIES];
  logic [lkv_pkg::CNT_W-1:0]   live_q;
  logic [lkv_pkg::CNT_W-1:0]   live_d;
  logic [lkv_pkg::CNT_W-1:0]   live_m1;
  logic [lkv_pkg::IDX_W-1:0]   old_rank;
  logic [lkv_pkg::IDX_W-1:0]   old_idx;
  logic [lkv_pkg::IDX_W-1:0]   hit_rank;
  logic [lkv_pkg::XW-1:0]      live_x;
  logic [lkv_pkg::XW-1:0]      cap_x;
  logic                        full;
  logic                        ins;
  logic [lkv_pkg::ENTRIES-1:0] valid_vec;
  lkv_pkg::lookup_t            res;

  assign live_m1  = live_q - lkv_pkg::CNT_W'(1);
  assign old_rank = live_m1[lkv_pkg::IDX_W-1:0];
  assign live_x   = lkv_pkg::XW'(live_q);
  assign cap_x    = lkv_pkg::XW'(cap_i);

  // capacity zero acts as one, anything above the built size is clipped
  always_comb begin
    if (live_q == lkv_pkg::CNT_W'(lkv_pkg::ENTRIES)) begin
      full = 1'b1;
    end else if (cap_x == '0) begin
      full = (live_x != '0);
    end else begin
      full = (live_x >= cap_x);
    end
  end

  always_comb begin
    res      = '0;
    old_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < int'(lkv_pkg::ENTRIES); i++) begin
      if (valid_q[i] && (key_q[i] == key_i)) begin
        res.hit     = 1'b1;
        res.hit_idx = res.hit_idx | lkv_pkg::IDX_W'(i);
        hit_rank    = hit_rank | rank_q[i];
      end
      // live ranks are distinct, so the oldest holds rank live_count - 1
      if (valid_q[i] && (rank_q[i] == old_rank)) begin
        old_idx = old_idx | lkv_pkg::IDX_W'(i);
      end
    end
    res.evict = (action_i == lkv_pkg::ACT_PUT) && !res.hit && full;
    for (int i = 0; i < int'(lkv_pkg::ENTRIES); i++) begin
      valid_ev[i] = valid_q[i] && !(res.evict && (old_idx == lkv_pkg::IDX_W'(i)));
    end
    // lowest free slot
    for (int i = int'(lkv_pkg::ENTRIES) - 1; i >= 0; i--) begin
      if (!valid_ev[i]) begin
        res.slot = lkv_pkg::IDX_W'(i);
      end
    end
  end

  assign res_o = res;
  assign ins   = (action_i == lkv_pkg::ACT_PUT) && !res.hit;

  always_comb begin
    for (int i = 0; i < int'(lkv_pkg::ENTRIES); i++) begin
      rank_d[i] = rank_q[i];
      if (res.hit) begin
        if (res.hit_idx == lkv_pkg::IDX_W'(i)) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + lkv_pkg::IDX_W'(1);
        end
      end else if (ins) begin
        if (res.slot == lkv_pkg::IDX_W'(i)) begin
          rank_d[i] = '0;
        end else if (valid_ev[i]) begin
          rank_d[i] = rank_q[i] + lkv_pkg::IDX_W'(1);
        end
      end
    end
    live_d = live_q;
    if (ins) begin
      live_d = res.evict ? live_q : live_q + lkv_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      for (int i = 0; i < int'(lkv_pkg::ENTRIES); i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
    end else if (lookup_en_i) begin
      live_q <= live_d;
      for (int i = 0; i < int'(lkv_pkg::ENTRIES); i++) begin
        rank_q[i] <= rank_d[i];
        if (ins) begin
          valid_q[i] <= valid_ev[i] || (res.slot == lkv_pkg::IDX_W'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_en_i && ins) begin
      key_q[res.slot] <= key_i;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(lkv_pkg::ENTRIES); i++) begin
      valid_vec[i] = valid_q[i];
    end
  end

`ifndef SYNTHESIS
  a_live_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(live_q))
    else $error("live count does not match valid bits");

  a_hit_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_en_i && res.hit |-> valid_vec[res.hit_idx])
    else $error("hit on an invalid entry");

  a_evict_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_en_i && res.evict |=> live_q == $past(live_q))
    else $error("eviction changed the live count");
`endif

endmodule
`default_nettype wire

>>> rtl/core/lru_key_value_cache_core.sv
// top level of the lru key-value cache: command sequencer and result port
`timescale 1ns / 1ps
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement.
// Command channel: an item (action_i, key_i, value_i) is taken at a clock edge
// where start_i is high and busy_o is low. action_i 0 looks a key up, 1 stores.
// The key is matched against all live tags in the cycle after acceptance while
// recency ranks, tags and the value RAM are updated; the result appears in the
// following cycle on hit_o, read_value_o and evicted_o with result_valid_o high
// for exactly one cycle. busy_o is high only in the match cycle, so a new word
// can be taken in the same cycle its predecessor's result is shown.
// The receiver has no way to stall; each result must be taken when shown.
// cfg_we_i / cfg_wdata_i write the capacity in use (reset 16); write it only
// while the block is idle. Reset empties the cache at once (valid bits and
// ranks are flops), so no clearing pass is needed.
module lru_key_value_cache_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output      logic                                 busy_o,
  input  wire logic                                 action_i,
  input  wire logic signed [lkv_pkg::DATA_W-1:0]    key_i,
  input  wire logic signed [lkv_pkg::DATA_W-1:0]    value_i,
  output      logic                                 result_valid_o,
  output      logic                                 hit_o,
  output      logic signed [lkv_pkg::DATA_W-1:0]    read_value_o,
  output      logic                                 evicted_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lkv_pkg::CFG_W-1:0]            cfg_wdata_i
);

  lkv_pkg::state_e                   state_q;
  lkv_pkg::state_e                   state_d;
  logic                              accept;
  logic                              lookup_en;
  logic [lkv_pkg::CFG_W-1:0]         cap_q;
  logic                              action_q;
  logic signed [lkv_pkg::DATA_W-1:0] key_q;
  logic signed [lkv_pkg::DATA_W-1:0] value_q;
  logic                              hit_q;
  logic                              evict_q;
  lkv_pkg::lookup_t                  res;
  logic                              ram_we;
  logic [lkv_pkg::IDX_W-1:0]         ram_waddr;
  logic [lkv_pkg::DATA_W-1:0]        ram_rdata;

  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkv_pkg::ST_IDLE:   if (start_i) state_d = lkv_pkg::ST_LOOKUP;
      lkv_pkg::ST_LOOKUP: state_d = lkv_pkg::ST_RESP;
      lkv_pkg::ST_RESP: begin
        state_d = start_i ? lkv_pkg::ST_LOOKUP : lkv_pkg::ST_IDLE;
      end
      default:            state_d = lkv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o         = 1'b0;
    lookup_en      = 1'b0;
    result_valid_o = 1'b0;
    unique case (state_q)
      lkv_pkg::ST_IDLE:   ;
      lkv_pkg::ST_LOOKUP: begin
        busy_o    = 1'b1;
        lookup_en = 1'b1;
      end
      lkv_pkg::ST_RESP:   result_valid_o = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkv_pkg::ST_IDLE;
      cap_q   <= lkv_pkg::CAP_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      key_q    <= key_i;
      value_q  <= value_i;
    end
    if (lookup_en) begin
      hit_q   <= res.hit;
      evict_q <= res.evict;
    end
  end

  lkv_tag_store u_tags (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_en_i (lookup_en),
    .action_i    (action_q),
    .key_i       (key_q),
    .cap_i       (cap_q),
    .res_o       (res)
  );

  // a put writes the hit entry or the new slot; a get only reads
  assign ram_we    = lookup_en && (action_q == lkv_pkg::ACT_PUT);
  assign ram_waddr = res.hit ? res.hit_idx : res.slot;

  lkv_value_ram u_values (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .raddr_i (res.hit_idx),
    .rdata_o (ram_rdata)
  );

  assign hit_o     = hit_q;
  assign evicted_o = evict_q;

  always_comb begin
    if (action_q == lkv_pkg::ACT_PUT) begin
      read_value_o = value_q;
    end else if (hit_q) begin
      read_value_o = ram_rdata;
    end else begin
      read_value_o = '1;
    end
  end

`ifndef SYNTHESIS
  a_result_after_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == lkv_pkg::ST_LOOKUP))
    else $error("result without a preceding lookup");

  a_busy_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o && result_valid_o)
    else $error("lookup did not hand over to the result cycle");

  a_evict_on_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && evicted_o |-> !hit_o && (action_q == lkv_pkg::ACT_PUT))
    else $error("eviction on a hit or a get");
`endif

endmodule
`default_nettype wire
